### rtl/core/qlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_pkg
// Shared types, constants and keyword tables of the query text tokenizer.
// ----------------------------------------------------------------------------
package qlt_pkg;

	// text buffer sizing
	localparam int MAX_TEXT = 32;
	localparam int LEN_W    = $clog2(MAX_TEXT + 1);
	localparam int ADDR_W   = $clog2(MAX_TEXT);

	// result field widths
	localparam int KIND_W = 5;
	localparam int NUM_W  = 31;
	localparam logic [NUM_W-1:0] NUM_MAX = '1;

	// token kinds
	localparam logic [KIND_W-1:0] KIND_DOT     = 5'd14;
	localparam logic [KIND_W-1:0] KIND_REGEX   = 5'd23;
	localparam logic [KIND_W-1:0] KIND_NUMBER  = 5'd24;
	localparam logic [KIND_W-1:0] KIND_ID      = 5'd25;
	localparam logic [KIND_W-1:0] KIND_INVALID = 5'd26;
	localparam logic [KIND_W-1:0] KIND_ERROR   = 5'd27;

	// special characters
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_BSL   = 8'h5C;

	// single-character tokens, kind is KIND_DOT plus the index
	localparam int PUNCT_N = 9;
	localparam logic [7:0] PUNCT_CHARS [PUNCT_N] = '{
		8'h2E, 8'h2C, 8'h3B, 8'h28, 8'h29, 8'h3C, 8'h3E, 8'h7B, 8'h7D
	};

	// keywords, left justified and padded to eight characters; kind is the index
	localparam int KW_N = 14;
	localparam logic [63:0] KW_STR [KW_N] = '{
		"create  ", "view    ", "as      ", "output  ", "select  ", "from    ",
		"extract ", "regex   ", "on      ", "return  ", "group   ", "and     ",
		"Token   ", "pattern "
	};
	localparam int KW_LEN [KW_N] = '{6, 4, 2, 6, 6, 4, 7, 5, 2, 6, 5, 3, 5, 7};

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_WORD,
		MODE_NUM,
		MODE_REGEX
	} scan_mode_t;

	typedef enum logic [1:0] {
		ST_ACCEPT,
		ST_RUN,
		ST_POST
	} ctl_state_t;

	// keyword candidate update for one appended word character
	typedef struct packed {
		logic             en;
		logic             first;
		logic [7:0]       ch;
		logic [LEN_W-1:0] pos;
	} kw_upd_t;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= 8'h30 && b <= 8'h39;
	endfunction

endpackage

### rtl/core/qlt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_text_if / qlt_token_if
// Valid/ready channels carrying query text bytes and result tokens.
// ----------------------------------------------------------------------------
interface qlt_text_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       is_end;

	modport source (output valid, output text_byte, output is_end, input ready);
	modport sink (input valid, input text_byte, input is_end, output ready);
endinterface

interface qlt_token_if
	import qlt_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] token_kind;
	logic [NUM_W-1:0]  number_value;
	logic [7:0]        text_char;
	logic              text_last;
	logic              run_last;

	modport source (output valid, output token_kind, output number_value,
		output text_char, output text_last, output run_last, input ready);
	modport sink (input valid, input token_kind, input number_value,
		input text_char, input text_last, input run_last, output ready);
endinterface

### rtl/core/query_language_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_language_tokenizer
// Byte-serial query text tokenizer with keyword, number, identifier and regex
// tokens; word and regex text is held in a small synchronous RAM.
// ----------------------------------------------------------------------------
// A single-result token is in the output register in the cycle after the
// byte is accepted. Identifier and regex runs are read from the text RAM one
// character at a time, each waiting for the registered read before handoff.
// Throughput: one byte per cycle when no result is pending; new text is held
// off while a run's characters or a trailing punctuation token are sent.
// Reset: arst_n clears mode, length, number and control state; the text RAM
// is not cleared and only entries below the current length are ever read.
// ----------------------------------------------------------------------------
module query_language_tokenizer
	import qlt_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	qlt_text_if.sink    text,
	qlt_token_if.source token
);

	// scan state
	scan_mode_t       mode_q, mode_d;
	logic [LEN_W-1:0] len_q, len_d;
	logic             ovf_q, ovf_d;
	logic             bs_q, bs_d;
	logic [NUM_W-1:0] acc_q, acc_d;

	// sequencer state
	ctl_state_t        state_q, state_d;
	logic [LEN_W-1:0]  run_len_q;
	logic [KIND_W-1:0] run_kind_q;
	logic [LEN_W-1:0]  rd_idx_q;
	logic              rd_ok_q;
	logic              post_v_q;
	logic [KIND_W-1:0] post_kind_q;

	// output register
	logic              out_valid_q;
	logic [KIND_W-1:0] kind_q;
	logic [NUM_W-1:0]  num_q;
	logic [7:0]        char_q;
	logic              tlast_q;
	logic              rlast_q;

	// decode results
	logic              pre_single, pre_run, pre_tlast, post_v;
	logic [KIND_W-1:0] pre_kind, post_kind;
	logic [NUM_W-1:0]  pre_num;
	logic              do_flush, do_idle, do_append;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	kw_upd_t           kwu;
	logic              kw_hit;
	logic [KIND_W-1:0] kw_kind;
	logic [7:0]        b;
	logic              b_space, b_alnum, punct_hit;
	logic [KIND_W-1:0] punct_kind;
	logic [34:0]       acc_mul;

	// handshake and push
	logic              out_free, in_ready, acc_fire, run_is_last;
	logic              push;
	logic [KIND_W-1:0] push_kind;
	logic [NUM_W-1:0]  push_num;
	logic [7:0]        push_char;
	logic              push_tlast, push_rlast;
	logic [7:0]        rd_data;

	assign b        = text.text_byte;
	assign b_space  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
	assign b_alnum  = is_letter(b) || is_digit(b);
	assign acc_mul  = 35'({acc_q, 3'b000}) + 35'({acc_q, 1'b0}) + 35'(b[3:0]);

	// punctuation lookup
	always_comb begin
		punct_hit  = 1'b0;
		punct_kind = KIND_INVALID;
		for (int k = 0; k < PUNCT_N; k++) begin
			if (b == PUNCT_CHARS[k]) begin
				punct_hit  = 1'b1;
				punct_kind = KIND_DOT + KIND_W'(k);
			end
		end
	end

	// per-byte decode: state update and results of one transaction
	always_comb begin
		mode_d     = mode_q;
		len_d      = len_q;
		ovf_d      = ovf_q;
		bs_d       = bs_q;
		acc_d      = acc_q;
		pre_single = 1'b0;
		pre_run    = 1'b0;
		pre_tlast  = 1'b0;
		pre_kind   = KIND_ERROR;
		pre_num    = '0;
		post_v     = 1'b0;
		post_kind  = KIND_INVALID;
		do_flush   = 1'b0;
		do_idle    = 1'b0;
		do_append  = 1'b0;
		wr_en      = 1'b0;
		wr_addr    = len_q[ADDR_W-1:0];
		kwu        = '0;
		kwu.ch     = b;
		kwu.pos    = len_q;

		if (text.is_end) begin
			unique case (mode_q)
				MODE_WORD: do_flush = 1'b1;
				MODE_NUM: begin
					pre_single = 1'b1;
					pre_kind   = KIND_NUMBER;
					pre_num    = acc_q;
					acc_d      = '0;
				end
				MODE_REGEX: begin
					pre_single = 1'b1;
					pre_kind   = KIND_ERROR;
					len_d      = '0;
					ovf_d      = 1'b0;
					bs_d       = 1'b0;
				end
				MODE_IDLE: ;
			endcase
			mode_d = MODE_IDLE;
		end else begin
			unique case (mode_q)
				MODE_WORD: begin
					if (b_alnum) begin
						do_append = 1'b1;
					end else begin
						do_flush = 1'b1;
						do_idle  = 1'b1;
					end
				end
				MODE_NUM: begin
					if (is_digit(b)) begin
						acc_d = (acc_mul > 35'(NUM_MAX)) ? NUM_MAX : acc_mul[NUM_W-1:0];
					end else begin
						pre_single = 1'b1;
						pre_kind   = KIND_NUMBER;
						pre_num    = acc_q;
						acc_d      = '0;
						do_idle    = 1'b1;
					end
				end
				MODE_REGEX: begin
					if (b == CH_SLASH && !bs_q) begin
						priority if (ovf_q) begin
							pre_single = 1'b1;
							pre_kind   = KIND_ERROR;
						end else if (len_q == '0) begin
							pre_single = 1'b1;
							pre_kind   = KIND_REGEX;
							pre_tlast  = 1'b1;
						end else begin
							pre_run  = 1'b1;
							pre_kind = KIND_REGEX;
						end
						len_d  = '0;
						ovf_d  = 1'b0;
						bs_d   = 1'b0;
						mode_d = MODE_IDLE;
					end else begin
						do_append = 1'b1;
						bs_d      = (b == CH_BSL);
					end
				end
				MODE_IDLE: do_idle = 1'b1;
			endcase
		end

		// append to the text buffer, or mark overflow
		if (do_append) begin
			if (len_q < LEN_W'(MAX_TEXT)) begin
				wr_en   = 1'b1;
				len_d   = len_q + LEN_W'(1);
				kwu.en  = (mode_q == MODE_WORD);
			end else begin
				ovf_d = 1'b1;
			end
		end

		// word ends: keyword, identifier run or error
		if (do_flush) begin
			priority if (!ovf_q && kw_hit) begin
				pre_single = 1'b1;
				pre_kind   = kw_kind;
			end else if (ovf_q) begin
				pre_single = 1'b1;
				pre_kind   = KIND_ERROR;
			end else if (len_q == '0) begin
				pre_single = 1'b1;
				pre_kind   = KIND_ID;
				pre_tlast  = 1'b1;
			end else begin
				pre_run  = 1'b1;
				pre_kind = KIND_ID;
			end
			len_d  = '0;
			ovf_d  = 1'b0;
			bs_d   = 1'b0;
			mode_d = MODE_IDLE;
		end

		// byte seen outside any token
		if (do_idle) begin
			mode_d = MODE_IDLE;
			priority if (b_space) begin
			end else if (b == CH_SLASH) begin
				len_d  = '0;
				ovf_d  = 1'b0;
				bs_d   = 1'b0;
				mode_d = MODE_REGEX;
			end else if (is_letter(b)) begin
				wr_en     = 1'b1;
				wr_addr   = '0;
				len_d     = LEN_W'(1);
				ovf_d     = 1'b0;
				bs_d      = 1'b0;
				kwu.en    = 1'b1;
				kwu.first = 1'b1;
				kwu.pos   = '0;
				mode_d    = MODE_WORD;
			end else if (is_digit(b)) begin
				acc_d  = NUM_W'(b[3:0]);
				mode_d = MODE_NUM;
			end else if (punct_hit) begin
				post_v    = 1'b1;
				post_kind = punct_kind;
			end else begin
				post_v    = 1'b1;
				post_kind = KIND_INVALID;
			end
		end
	end

	assign out_free    = !out_valid_q || token.ready;
	assign in_ready    = (state_q == ST_ACCEPT) && out_free;
	assign acc_fire    = text.valid && in_ready;
	assign text.ready  = in_ready;
	assign run_is_last = (rd_idx_q == (run_len_q - LEN_W'(1)));

	qlt_text_ram u_ram (
		.clk   (clk),
		.we    (wr_en && acc_fire),
		.waddr (wr_addr),
		.wdata (b),
		.raddr (rd_idx_q[ADDR_W-1:0]),
		.rdata (rd_data)
	);

	kw_upd_t kwu_gated;
	always_comb begin
		kwu_gated    = kwu;
		kwu_gated.en = kwu.en && acc_fire;
	end

	qlt_kw_match u_kw (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (kwu_gated),
		.text_len (len_q),
		.hit      (kw_hit),
		.hit_kind (kw_kind)
	);

	// sequencer next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_ACCEPT: begin
				if (acc_fire) begin
					priority if (pre_run) begin
						state_d = ST_RUN;
					end else if (pre_single && post_v) begin
						state_d = ST_POST;
					end else begin
						state_d = ST_ACCEPT;
					end
				end
			end
			ST_RUN: begin
				if (push && run_is_last) begin
					state_d = post_v_q ? ST_POST : ST_ACCEPT;
				end
			end
			ST_POST: begin
				if (out_free) begin
					state_d = ST_ACCEPT;
				end
			end
			default: state_d = ST_ACCEPT;
		endcase
	end

	// sequencer outputs: result pushed into the output register
	always_comb begin
		push       = 1'b0;
		push_kind  = pre_kind;
		push_num   = '0;
		push_char  = '0;
		push_tlast = 1'b0;
		push_rlast = 1'b0;
		unique case (state_q)
			ST_ACCEPT: begin
				priority if (acc_fire && pre_single) begin
					push       = 1'b1;
					push_kind  = pre_kind;
					push_num   = pre_num;
					push_tlast = pre_tlast;
					push_rlast = !post_v;
				end else if (acc_fire && !pre_run && post_v) begin
					push       = 1'b1;
					push_kind  = post_kind;
					push_rlast = 1'b1;
				end else begin
				end
			end
			ST_RUN: begin
				push       = rd_ok_q && out_free;
				push_kind  = run_kind_q;
				push_char  = rd_data;
				push_tlast = run_is_last;
				push_rlast = run_is_last && !post_v_q;
			end
			ST_POST: begin
				push       = out_free;
				push_kind  = post_kind_q;
				push_rlast = 1'b1;
			end
			default: ;
		endcase
	end

	// scan state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			len_q  <= '0;
			ovf_q  <= 1'b0;
			bs_q   <= 1'b0;
			acc_q  <= '0;
		end else if (acc_fire) begin
			mode_q <= mode_d;
			len_q  <= len_d;
			ovf_q  <= ovf_d;
			bs_q   <= bs_d;
			acc_q  <= acc_d;
		end
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACCEPT;
			run_len_q   <= '0;
			run_kind_q  <= KIND_ID;
			rd_idx_q    <= '0;
			rd_ok_q     <= 1'b0;
			post_v_q    <= 1'b0;
			post_kind_q <= KIND_INVALID;
		end else begin
			state_q <= state_d;
			if (acc_fire) begin
				run_len_q   <= len_q;
				run_kind_q  <= pre_kind;
				rd_idx_q    <= '0;
				rd_ok_q     <= 1'b0;
				post_v_q    <= post_v;
				post_kind_q <= post_kind;
			end else if (state_q == ST_RUN) begin
				if (push) begin
					rd_idx_q <= rd_idx_q + LEN_W'(1);
					rd_ok_q  <= 1'b0;
				end else begin
					rd_ok_q <= 1'b1;
				end
			end
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (token.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (push) begin
			kind_q  <= push_kind;
			num_q   <= push_num;
			char_q  <= push_char;
			tlast_q <= push_tlast;
			rlast_q <= push_rlast;
		end
	end

	assign token.valid        = out_valid_q;
	assign token.token_kind   = kind_q;
	assign token.number_value = num_q;
	assign token.text_char    = char_q;
	assign token.text_last    = tlast_q;
	assign token.run_last     = rlast_q;

`ifndef SYNTHESIS
	// text run flag only on identifier or regex tokens
	a_tlast_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && tlast_q |-> (kind_q == KIND_REGEX || kind_q == KIND_ID))
		else $error("text_last on a non-text token");

	// nonzero value only on number tokens
	a_num_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (num_q != '0) |-> (kind_q == KIND_NUMBER))
		else $error("number value on a non-number token");

	// run read index stays inside the buffered text
	a_run_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (rd_idx_q < run_len_q))
		else $error("run index past text length");

	// a run never starts on an empty buffer
	a_run_len: assert property (@(posedge clk) disable iff (!arst_n)
		acc_fire && pre_run |=> (run_len_q != '0) && (run_len_q <= LEN_W'(MAX_TEXT)))
		else $error("run length out of range");
`endif

endmodule

### rtl/core/qlt_text_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_text_ram
// Word and regex text buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
module qlt_text_ram
	import qlt_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [7:0]        rdata
);

	logic [7:0] mem [MAX_TEXT];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/qlt_kw_match.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qlt_kw_match
// Tracks which keywords the buffered word still matches, one character at a
// time, and reports the keyword whose length equals the word length.
// ----------------------------------------------------------------------------
module qlt_kw_match
	import qlt_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  kw_upd_t           upd,
	input  logic [LEN_W-1:0]  text_len,
	output logic              hit,
	output logic [KIND_W-1:0] hit_kind
);

	logic [KW_N-1:0] cand_q;
	logic [KW_N-1:0] cand_d;
	logic [KW_N-1:0] base;

	// narrow candidate set by the new character
	always_comb begin
		base = upd.first ? '1 : cand_q;
		for (int k = 0; k < KW_N; k++) begin
			cand_d[k] = base[k] && (upd.pos < LEN_W'(KW_LEN[k])) &&
				(KW_STR[k][{~upd.pos[2:0], 3'b000} +: 8] == upd.ch);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cand_q <= '0;
		end else if (upd.en) begin
			cand_q <= cand_d;
		end
	end

	// surviving candidate with the exact length
	always_comb begin
		hit      = 1'b0;
		hit_kind = '0;
		for (int k = 0; k < KW_N; k++) begin
			if (!hit && cand_q[k] && (text_len == LEN_W'(KW_LEN[k]))) begin
				hit      = 1'b1;
				hit_kind = KIND_W'(k);
			end
		end
	end

endmodule

### test/query_language_tokenizer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_language_tokenizer_checker
// Watches the text and token channels of the tokenizer. Every accepted text
// transaction is run through a bit-accurate token predictor, and every
// accepted token transaction is compared field by field with the oldest
// predicted token.
// ----------------------------------------------------------------------------
module query_language_tokenizer_checker
	import qlt_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	qlt_text_if  text,
	qlt_token_if token,
	output int   fail_count,
	output int   pending
);

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NUM_W-1:0]  value;
		logic [7:0]        ch;
		logic              text_last;
		logic              run_last;
	} token_t;

	localparam logic [7:0] CH_ZERO = 8'h30;

	// keyword text, the kind is the index
	string keyword_list [14] = '{
		"create", "view", "as", "output", "select", "from", "extract",
		"regex", "on", "return", "group", "and", "Token", "pattern"
	};
	// single-character tokens, the kind is KIND_DOT plus the index
	logic [7:0] punct_list [9] = '{".", ",", ";", "(", ")", "<", ">", "{", "}"};

	// predicted tokenizer state
	scan_mode_t       mode;
	logic [7:0]       word_buf [MAX_TEXT];
	int               word_len;
	logic [NUM_W-1:0] num_acc;
	logic             after_bsl;
	logic             overlong;

	// tokens of the current text transaction, and all tokens still due
	token_t step_tokens [$];
	token_t due_tokens [$];

	function automatic logic is_alpha(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_num(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF;
	endfunction

	task automatic add_token(input logic [KIND_W-1:0] kind, input logic [NUM_W-1:0] value,
		input logic [7:0] ch, input logic text_last);
		token_t t;
		t.kind      = kind;
		t.value     = value;
		t.ch        = ch;
		t.text_last = text_last;
		t.run_last  = 1'b0;
		step_tokens = {step_tokens, t};
	endtask

	task automatic store_char(input logic [7:0] b);
		if (word_len < MAX_TEXT) begin
			word_buf[word_len] = b;
			word_len++;
		end else begin
			overlong = 1'b1;
		end
	endtask

	task automatic clear_text();
		word_len  = 0;
		overlong  = 1'b0;
		after_bsl = 1'b0;
	endtask

	// buffered text as a character run, or a single error when too long
	task automatic emit_run(input logic [KIND_W-1:0] kind);
		if (overlong) begin
			add_token(KIND_ERROR, '0, 8'h00, 1'b0);
		end else if (word_len == 0) begin
			add_token(kind, '0, 8'h00, 1'b1);
		end else begin
			for (int i = 0; i < word_len; i++)
				add_token(kind, '0, word_buf[i], i == word_len - 1);
		end
	endtask

	// keyword lookup, identifier run when nothing matches
	task automatic flush_word();
		logic hit;
		logic same;
		hit = 1'b0;
		if (!overlong) begin
			foreach (keyword_list[k]) begin
				if (!hit && keyword_list[k].len() == word_len) begin
					same = 1'b1;
					for (int i = 0; i < word_len; i++)
						if (keyword_list[k][i] != word_buf[i])
							same = 1'b0;
					if (same) begin
						add_token(KIND_W'(k), '0, 8'h00, 1'b0);
						hit = 1'b1;
					end
				end
			end
		end
		if (!hit)
			emit_run(KIND_ID);
		clear_text();
	endtask

	// a byte seen outside any word, number or regex
	task automatic start_byte(input logic [7:0] b);
		logic found;
		found = 1'b0;
		mode = MODE_IDLE;
		if (is_blank(b)) begin
			found = 1'b1;
		end else if (b == CH_SLASH) begin
			clear_text();
			mode = MODE_REGEX;
		end else if (is_alpha(b)) begin
			clear_text();
			store_char(b);
			mode = MODE_WORD;
		end else if (is_num(b)) begin
			num_acc = NUM_W'(b - CH_ZERO);
			mode = MODE_NUM;
		end else begin
			foreach (punct_list[k]) begin
				if (!found && punct_list[k] == b) begin
					add_token(KIND_DOT + KIND_W'(k), '0, 8'h00, 1'b0);
					found = 1'b1;
				end
			end
			if (!found)
				add_token(KIND_INVALID, '0, 8'h00, 1'b0);
		end
	endtask

	task automatic flush_number();
		add_token(KIND_NUMBER, num_acc, 8'h00, 1'b0);
		num_acc = '0;
	endtask

	// tokens caused by one text transaction
	task automatic predict_tokens(input logic [7:0] b, input logic at_end);
		logic [NUM_W+3:0] wide;
		step_tokens.delete();
		if (at_end) begin
			case (mode)
				MODE_WORD:  flush_word();
				MODE_NUM:   flush_number();
				MODE_REGEX: begin
					add_token(KIND_ERROR, '0, 8'h00, 1'b0);
					clear_text();
				end
				default: ;
			endcase
			mode = MODE_IDLE;
		end else begin
			case (mode)
				MODE_WORD: begin
					if (is_alpha(b) || is_num(b)) begin
						store_char(b);
					end else begin
						flush_word();
						start_byte(b);
					end
				end
				MODE_NUM: begin
					if (is_num(b)) begin
						// saturating decimal accumulate
						wide = (NUM_W+4)'(num_acc) * 10 + (NUM_W+4)'(b - CH_ZERO);
						num_acc = (wide > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : wide[NUM_W-1:0];
					end else begin
						flush_number();
						start_byte(b);
					end
				end
				MODE_REGEX: begin
					if (b == CH_SLASH && !after_bsl) begin
						emit_run(KIND_REGEX);
						clear_text();
						mode = MODE_IDLE;
					end else begin
						store_char(b);
						after_bsl = (b == CH_BSL);
					end
				end
				default: start_byte(b);
			endcase
		end
		if (step_tokens.size() > 0)
			step_tokens[step_tokens.size() - 1].run_last = 1'b1;
		due_tokens = {due_tokens, step_tokens};
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			fail_count++;
			$display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// compare accepted tokens, then predict from accepted text
	always @(posedge clk or negedge arst_n) begin
		token_t want;
		if (!arst_n) begin
			mode      = MODE_IDLE;
			word_len  = 0;
			num_acc   = '0;
			after_bsl = 1'b0;
			overlong  = 1'b0;
			due_tokens.delete();
			pending <= 0;
		end else begin
			if (token.valid && token.ready) begin
				if (due_tokens.size() == 0) begin
					fail_count++;
					$display("%0t ns: token expected none, got kind %0d value %0d char %0d",
						$time, token.token_kind, token.number_value, token.text_char);
				end else begin
					want = due_tokens.pop_front();
					check_field("token_kind", 32'(want.kind), 32'(token.token_kind));
					check_field("number_value", 32'(want.value), 32'(token.number_value));
					check_field("text_char", 32'(want.ch), 32'(token.text_char));
					check_field("text_last", 32'(want.text_last), 32'(token.text_last));
					check_field("run_last", 32'(want.run_last), 32'(token.run_last));
				end
			end
			if (text.valid && text.ready)
				predict_tokens(text.text_byte, text.is_end);
			pending <= due_tokens.size();
		end
	end

endmodule

### test/query_language_tokenizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// query_language_tokenizer_tb
// Feeds query text to the tokenizer: a short directed sequence for blanks,
// keywords, punctuation, invalid bytes, regex escapes and end handling, then
// random token-shaped text with noise, long words and long regexes. Both
// channels idle at random; the checker beside the block judges the tokens.
// ----------------------------------------------------------------------------
module query_language_tokenizer_tb;
	import qlt_pkg::*;

	localparam int RANDOM_ITEMS = 420;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count;
	int   pending;
	int   sent = 0;
	bit   steady = 1'b0;
	bit   drained_once = 1'b0;

	qlt_text_if  text_ch ();
	qlt_token_if token_ch ();

	query_language_tokenizer dut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.token  (token_ch)
	);

	query_language_tokenizer_checker token_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.token      (token_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mostly no gap, some short ones, a few long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_digit();
		return 8'("0" + $urandom_range(0, 9));
	endfunction

	function automatic logic [7:0] rand_alnum();
		return ($urandom_range(0, 3) == 0) ? rand_digit() : rand_letter();
	endfunction

	function automatic logic [7:0] rand_blank();
		case ($urandom_range(0, 3))
			0:       return CH_SPACE;
			1:       return CH_TAB;
			2:       return CH_CR;
			default: return CH_LF;
		endcase
	endfunction

	// one text transaction, after a random gap
	task automatic send_item(input logic [7:0] b, input logic at_end);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			text_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.text_byte <= b;
		text_ch.is_end    <= at_end;
		do @(posedge clk); while (!text_ch.ready);
		sent++;
	endtask

	task automatic send_text(input string s);
		foreach (s[i])
			send_item(s[i], 1'b0);
	endtask

	// first n characters of a keyword
	task automatic send_keyword(input int k, input int n);
		for (int i = 0; i < n; i++)
			send_item(KW_STR[k][63 - 8 * i -: 8], 1'b0);
	endtask

	// hold off text until every predicted token has come out
	task automatic wait_drained();
		text_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
	endtask

	// optional byte that ends a word or number
	task automatic maybe_separate();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			send_item(rand_blank(), 1'b0);
		else if (r < 6)
			send_item(PUNCT_CHARS[$urandom_range(0, PUNCT_N - 1)], 1'b0);
		else if (r < 7)
			send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	// one random token or piece of noise
	task automatic random_token();
		int r;
		int n;
		int k;
		logic [7:0] b;
		logic [7:0] prev;
		r = $urandom_range(0, 99);
		if (r < 18) begin
			k = $urandom_range(0, KW_N - 1);
			send_keyword(k, KW_LEN[k]);
			maybe_separate();
		end else if (r < 32) begin
			// identifiers, with near-miss keywords and a few past the buffer size
			if ($urandom_range(0, 3) == 0) begin
				k = $urandom_range(0, KW_N - 1);
				send_keyword(k, KW_LEN[k] - 1);
				if ($urandom_range(0, 1) == 1)
					send_item(rand_alnum(), 1'b0);
			end else begin
				n = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 36) : $urandom_range(0, 7);
				send_item(rand_letter(), 1'b0);
				repeat (n) send_item(rand_alnum(), 1'b0);
			end
			maybe_separate();
		end else if (r < 46) begin
			// numbers, a few long enough to saturate
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 4);
			repeat (n) send_item(rand_digit(), 1'b0);
			maybe_separate();
		end else if (r < 58) begin
			// regex with any bytes, slashes escaped
			send_item(CH_SLASH, 1'b0);
			prev = 8'h00;
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 36) : $urandom_range(0, 6);
			repeat (n) begin
				b = 8'($urandom_range(0, 255));
				if (b == CH_SLASH)
					send_item(CH_BSL, 1'b0);
				send_item(b, 1'b0);
				prev = b;
			end
			if ($urandom_range(0, 9) == 0) begin
				send_item(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				if (prev == CH_BSL)
					send_item("x", 1'b0);
				send_item(CH_SLASH, 1'b0);
			end
		end else if (r < 70) begin
			send_item(PUNCT_CHARS[$urandom_range(0, PUNCT_N - 1)], 1'b0);
		end else if (r < 80) begin
			repeat ($urandom_range(1, 3)) send_item(rand_blank(), 1'b0);
		end else if (r < 90) begin
			send_item(8'($urandom_range(0, 255)), 1'b0);
		end else begin
			send_item(8'($urandom_range(0, 255)), 1'b1);
		end
	endtask

	// token sink stalls
	initial begin
		int stall;
		forever begin
			token_ch.ready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			if (steady)
				stall = 0;
			else if ($urandom_range(0, 9) == 0)
				stall = $urandom_range(8, 30);
			else
				stall = $urandom_range(0, 3);
			if (stall > 0) begin
				token_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// reset, stimulus and verdict
	initial begin
		int start_count;
		text_ch.valid     <= 1'b0;
		text_ch.text_byte <= 8'h00;
		text_ch.is_end    <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blanks, keyword, identifier, invalid extremes, punctuation
		send_item(CH_SPACE, 1'b0);
		send_item(CH_TAB, 1'b0);
		send_text("as.");
		send_text("x9,");
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("<>{};()");
		// empty regex, escaped slash, end flushes and an unterminated regex
		send_text("//");
		send_text("/\\//");
		send_text("7");
		send_item(8'hA5, 1'b1);
		send_text("/q");
		send_item(8'h00, 1'b1);
		send_item(8'hFF, 1'b1);

		start_count = sent;
		while (sent - start_count < RANDOM_ITEMS) begin
			if ($urandom_range(0, 19) == 0)
				steady = !steady;
			if (!drained_once && sent - start_count >= RANDOM_ITEMS / 2) begin
				wait_drained();
				drained_once = 1'b1;
			end
			random_token();
		end
		steady = 1'b0;

		wait_drained();
		repeat (16) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

### query_language_tokenizer.f
rtl/core/qlt_pkg.sv
rtl/core/qlt_if.sv
rtl/core/qlt_text_ram.sv
rtl/core/qlt_kw_match.sv
rtl/core/query_language_tokenizer.sv
test/query_language_tokenizer_checker.sv
test/query_language_tokenizer_tb.sv
